[rtl/core/tbr_pkg.sv]
// ----------------------------------------------------------------------------
// tbr_pkg
// Shared types and codes for the trial-boot rollback supervisor.
// ----------------------------------------------------------------------------
package tbr_pkg;

   // Event opcodes
   localparam logic [2:0] OP_LOAD         = 3'd0;
   localparam logic [2:0] OP_BOOT_REQ     = 3'd1;
   localparam logic [2:0] OP_HEALTH       = 3'd2;
   localparam logic [2:0] OP_CONFIRM      = 3'd3;
   localparam logic [2:0] OP_FAULT        = 3'd4;
   localparam logic [2:0] OP_RB_START     = 3'd5;
   localparam logic [2:0] OP_RB_COMPLETE  = 3'd6;

   // Record state codes
   localparam logic [2:0] ST_OTHER        = 3'd0;
   localparam logic [2:0] ST_CONFIRMED    = 3'd1;
   localparam logic [2:0] ST_TRIAL        = 3'd2;
   localparam logic [2:0] ST_PENDING      = 3'd3;
   localparam logic [2:0] ST_ROLLING      = 3'd4;

   // Result codes
   localparam logic [2:0] RC_OK           = 3'd0;
   localparam logic [2:0] RC_NOT_READY    = 3'd1;
   localparam logic [2:0] RC_BAD_STATE    = 3'd2;
   localparam logic [2:0] RC_BOOT_JUMP    = 3'd3;
   localparam logic [2:0] RC_BOOT_ROLLBACK = 3'd4;
   localparam logic [2:0] RC_BOOT_INVALID = 3'd5;

   // Config register indexes
   localparam logic [1:0] CSR_MAX_TRIAL   = 2'd0;
   localparam logic [1:0] CSR_CONFIRM_MS  = 2'd1;
   localparam logic [1:0] CSR_LIMIT_CODE  = 2'd2;

   localparam logic [4:0] ALL_HEALTHY     = 5'h1f;

   // Config register reset values
   localparam logic [7:0]  MAX_TRIAL_RST  = 8'd3;
   localparam logic [31:0] CONFIRM_MS_RST = 32'd30000;
   localparam logic [31:0] LIMIT_CODE_RST = 32'd1;

   typedef struct packed {
      logic [7:0]  max_trial_boots;
      logic [31:0] confirm_time_ms;
      logic [31:0] boot_limit_code;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  result_code;
      logic [2:0]  out_state;
      logic [7:0]  out_trial_count;
      logic [31:0] out_error;
      logic [31:0] out_active_version;
      logic [31:0] out_confirmed_counter;
   } rsp_type;

endpackage

[rtl/core/tbr_csr.sv]
// ----------------------------------------------------------------------------
// tbr_csr
// Configuration registers; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module tbr_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_data,
   output tbr_pkg::cfg_type cfg
);

   tbr_pkg::cfg_type cfg_ff;
   tbr_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            tbr_pkg::CSR_MAX_TRIAL:  cfg_in.max_trial_boots = csr_data[7:0];
            tbr_pkg::CSR_CONFIRM_MS: cfg_in.confirm_time_ms = csr_data;
            tbr_pkg::CSR_LIMIT_CODE: cfg_in.boot_limit_code = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_trial_boots <= tbr_pkg::MAX_TRIAL_RST;
         cfg_ff.confirm_time_ms <= tbr_pkg::CONFIRM_MS_RST;
         cfg_ff.boot_limit_code <= tbr_pkg::LIMIT_CODE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/core/tbr_engine.sv]
// ----------------------------------------------------------------------------
// tbr_engine
// Update record registers and the combinational event update.
// ----------------------------------------------------------------------------
module tbr_engine (
   input  logic             clock,
   input  logic             reset,
   input  tbr_pkg::cfg_type cfg,
   input  logic             accept,
   input  logic [2:0]       req_op,
   input  logic [31:0]      req_uptime_ms,
   input  logic [4:0]       req_health_flags,
   input  logic [31:0]      req_fault_code,
   input  logic [2:0]       req_load_state,
   input  logic [7:0]       req_load_trial_count,
   input  logic [31:0]      req_load_version,
   input  logic [31:0]      req_load_counter,
   output tbr_pkg::rsp_type result
);

   logic [2:0]  state_ff,  state_in;
   logic [7:0]  trial_ff,  trial_in;
   logic [31:0] err_ff,    err_in;
   logic [31:0] active_ff, active_in;
   logic [31:0] ccnt_ff,   ccnt_in;
   logic [31:0] sver_ff,   sver_in;
   logic [31:0] scnt_ff,   scnt_in;
   logic [2:0]  rc;

   // event decode and record update
   always_comb begin
      state_in  = state_ff;
      trial_in  = trial_ff;
      err_in    = err_ff;
      active_in = active_ff;
      ccnt_in   = ccnt_ff;
      sver_in   = sver_ff;
      scnt_in   = scnt_ff;
      rc        = tbr_pkg::RC_BAD_STATE;
      case (req_op)
         tbr_pkg::OP_LOAD: begin
            state_in = (req_load_state inside {[tbr_pkg::ST_OTHER:tbr_pkg::ST_ROLLING]}) ?
                       req_load_state : tbr_pkg::ST_OTHER;
            trial_in = req_load_trial_count;
            sver_in  = req_load_version;
            scnt_in  = req_load_counter;
            err_in   = 32'd0;
            rc       = tbr_pkg::RC_OK;
         end
         tbr_pkg::OP_BOOT_REQ: begin
            if (state_ff != tbr_pkg::ST_TRIAL) begin
               rc = tbr_pkg::RC_BOOT_INVALID;
            end else if (trial_ff >= cfg.max_trial_boots) begin
               state_in = tbr_pkg::ST_PENDING;
               err_in   = cfg.boot_limit_code;
               rc       = tbr_pkg::RC_BOOT_ROLLBACK;
            end else begin
               trial_in = trial_ff + 8'd1;
               rc       = tbr_pkg::RC_BOOT_JUMP;
            end
         end
         tbr_pkg::OP_HEALTH: begin
            rc = (req_uptime_ms >= cfg.confirm_time_ms &&
                  req_health_flags == tbr_pkg::ALL_HEALTHY) ?
                 tbr_pkg::RC_OK : tbr_pkg::RC_NOT_READY;
         end
         tbr_pkg::OP_CONFIRM: begin
            if (state_ff == tbr_pkg::ST_TRIAL) begin
               state_in  = tbr_pkg::ST_CONFIRMED;
               active_in = sver_ff;
               ccnt_in   = scnt_ff;
               trial_in  = 8'd0;
               err_in    = 32'd0;
               rc        = tbr_pkg::RC_OK;
            end
         end
         tbr_pkg::OP_FAULT: begin
            if (state_ff == tbr_pkg::ST_TRIAL) begin
               state_in = tbr_pkg::ST_PENDING;
               err_in   = req_fault_code;
               rc       = tbr_pkg::RC_OK;
            end
         end
         tbr_pkg::OP_RB_START: begin
            if (state_ff == tbr_pkg::ST_ROLLING) begin
               rc = tbr_pkg::RC_OK;
            end else if (state_ff == tbr_pkg::ST_PENDING) begin
               state_in = tbr_pkg::ST_ROLLING;
               rc       = tbr_pkg::RC_OK;
            end
         end
         tbr_pkg::OP_RB_COMPLETE: begin
            if (state_ff == tbr_pkg::ST_ROLLING) begin
               state_in = tbr_pkg::ST_CONFIRMED;
               trial_in = 8'd0;
               err_in   = 32'd0;
               rc       = tbr_pkg::RC_OK;
            end
         end
         default: ;
      endcase
   end

   // record registers, updated only on an accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= tbr_pkg::ST_CONFIRMED;
         trial_ff  <= 8'd0;
         err_ff    <= 32'd0;
         active_ff <= 32'd0;
         ccnt_ff   <= 32'd0;
         sver_ff   <= 32'd0;
         scnt_ff   <= 32'd0;
      end else if (accept) begin
         state_ff  <= state_in;
         trial_ff  <= trial_in;
         err_ff    <= err_in;
         active_ff <= active_in;
         ccnt_ff   <= ccnt_in;
         sver_ff   <= sver_in;
         scnt_ff   <= scnt_in;
      end
   end

   // result snapshot reflects the record after the event
   always_comb begin
      result.result_code           = rc;
      result.out_state             = state_in;
      result.out_trial_count       = trial_in;
      result.out_error             = err_in;
      result.out_active_version    = active_in;
      result.out_confirmed_counter = ccnt_in;
   end

`ifndef SYNTH
   a_state_legal: assert property (@(posedge clock) disable iff (reset)
      state_ff <= tbr_pkg::ST_ROLLING)
      else $error("record state out of range");

   a_boot_jump: assert property (@(posedge clock) disable iff (reset)
      accept && req_op == tbr_pkg::OP_BOOT_REQ && state_ff == tbr_pkg::ST_TRIAL &&
      trial_ff < cfg.max_trial_boots
      |=> trial_ff == $past(trial_ff) + 8'd1)
      else $error("boot jump did not advance trial count");

   a_confirm: assert property (@(posedge clock) disable iff (reset)
      accept && req_op == tbr_pkg::OP_CONFIRM && state_ff == tbr_pkg::ST_TRIAL
      |=> state_ff == tbr_pkg::ST_CONFIRMED && active_ff == $past(sver_ff) &&
          ccnt_ff == $past(scnt_ff))
      else $error("confirm did not promote staged image");
`endif

endmodule

[rtl/core/tbr_rsp_buf.sv]
// ----------------------------------------------------------------------------
// tbr_rsp_buf
// Two-entry result buffer: output register plus skid slot.
// ----------------------------------------------------------------------------
module tbr_rsp_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tbr_pkg::rsp_type push_data,
   output logic             not_full,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tbr_pkg::rsp_type rsp_data
);

   logic [1:0]       count_ff, count_in;
   tbr_pkg::rsp_type slot0_ff, slot0_in;
   tbr_pkg::rsp_type slot1_ff, slot1_in;
   logic             pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign not_full  = (count_ff != 2'd2);
   assign pop       = rsp_valid & rsp_ready;
   assign rsp_data  = slot0_ff;

   // slot steering
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      if (count_ff == 2'd2 && pop) begin
         slot0_in = slot1_ff;
      end
      if (push) begin
         if (count_ff == 2'd0 || (count_ff == 2'd1 && pop)) begin
            slot0_in = push_data;
         end else begin
            slot1_in = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer count overflow");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff != 2'd2)
      else $error("push into full result buffer");

   a_skid_shift: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 && pop |=> slot0_ff == $past(slot1_ff))
      else $error("skid entry not moved to output");
`endif

endmodule

[rtl/core/trial_boot_rollback_fsm_top.sv]
// ----------------------------------------------------------------------------
// trial_boot_rollback_fsm_top
// Trial-boot supervisor for A/B firmware updates.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    op, uptime, flags, fault, load_*
//   rsp      out        rsp_valid/rsp_ready    result code and record snapshot
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// One transaction per cycle while req_ready is high; the record updates at
// the accept edge, where the result is also written into the result buffer.
// A two-entry result buffer keeps req_ready high while one result waits;
// req_ready drops only when both entries are held.
// Synchronous reset restores the confirmed record and the default config.
// ----------------------------------------------------------------------------
module trial_boot_rollback_fsm_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic [31:0] req_uptime_ms,
   input  logic [4:0]  req_health_flags,
   input  logic [31:0] req_fault_code,
   input  logic [2:0]  req_load_state,
   input  logic [7:0]  req_load_trial_count,
   input  logic [31:0] req_load_version,
   input  logic [31:0] req_load_counter,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_result_code,
   output logic [2:0]  rsp_out_state,
   output logic [7:0]  rsp_out_trial_count,
   output logic [31:0] rsp_out_error,
   output logic [31:0] rsp_out_active_version,
   output logic [31:0] rsp_out_confirmed_counter,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   tbr_pkg::cfg_type cfg;
   tbr_pkg::rsp_type result;
   tbr_pkg::rsp_type rsp_data;
   logic             accept;
   logic             not_full;

   assign req_ready = not_full;
   assign accept    = req_valid & not_full;

   // configuration registers
   tbr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // record and event update
   tbr_engine u_engine (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg),
      .accept               (accept),
      .req_op               (req_op),
      .req_uptime_ms        (req_uptime_ms),
      .req_health_flags     (req_health_flags),
      .req_fault_code       (req_fault_code),
      .req_load_state       (req_load_state),
      .req_load_trial_count (req_load_trial_count),
      .req_load_version     (req_load_version),
      .req_load_counter     (req_load_counter),
      .result               (result)
   );

   // result buffer
   tbr_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (result),
      .not_full  (not_full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_result_code           = rsp_data.result_code;
   assign rsp_out_state             = rsp_data.out_state;
   assign rsp_out_trial_count       = rsp_data.out_trial_count;
   assign rsp_out_error             = rsp_data.out_error;
   assign rsp_out_active_version    = rsp_data.out_active_version;
   assign rsp_out_confirmed_counter = rsp_data.out_confirmed_counter;

endmodule
